[design/bftc_pkg.sv]
`default_nettype none

package bftc_pkg;

  // Field and state widths fixed by the console item format.
  localparam int POS_W   = 13;
  localparam int POSX_W  = POS_W + 1;
  localparam int ADDR_W  = 48;
  localparam int COLOR_W = 32;
  localparam int CODE_W  = 8;
  localparam int GROW_W  = 4;
  localparam int MASK_W  = 8;
  localparam int REGI_W  = 3;
  localparam int CFGD_W  = 48;
  // Pixel offset x + y * stride needs 27 bits at most.
  localparam int PIX_W   = 27;
  localparam int CELL_W  = 8;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_NEWLINE   = 2'd1,
    KIND_BACKSPACE = 2'd2,
    KIND_LOAD      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_op_t;

  typedef enum logic {
    OP_ROW_WRITE = 1'b0,
    OP_CLEAR     = 1'b1
  } out_op_t;

  typedef enum logic [REGI_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_LINE_STRIDE   = 3'd2,
    REG_FRAME_BASE    = 3'd3,
    REG_INK_COLOR     = 3'd4,
    REG_ERASE_COLOR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]   screen_width;
    logic [POS_W-1:0]   screen_height;
    logic [POS_W-1:0]   line_stride;
    logic [ADDR_W-1:0]  frame_base;
    logic [COLOR_W-1:0] ink_color;
    logic [COLOR_W-1:0] erase_color;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    screen_width:  13'd640,
    screen_height: 13'd480,
    line_stride:   13'd640,
    frame_base:    48'd0,
    ink_color:     32'hffff_ffff,
    erase_color:   32'd0
  };

  // One classified command handed from the front to the back.
  typedef struct packed {
    cmd_op_t           op;
    logic              clear;
    logic              blank;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] grow;
    logic [MASK_W-1:0] bits;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

`default_nettype wire

[design/bftc_if.sv]
`default_nettype none

interface bftc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [3:0] glyph_row;
  logic [7:0] row_bits;

  modport source (output valid, kind, char_code, glyph_row, row_bits, input ready);
  modport sink   (input valid, kind, char_code, glyph_row, row_bits, output ready);
endinterface

interface bftc_out_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [47:0] pixel_address;
  logic [7:0]  pixel_mask;
  logic [31:0] pixel_color;
  logic        last;

  modport source (output valid, op, pixel_address, pixel_mask, pixel_color, last,
                  input ready);
  modport sink   (input valid, op, pixel_address, pixel_mask, pixel_color, last,
                  output ready);
endinterface

interface bftc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/bftc_front.sv]
`default_nettype none

module bftc_front
  import bftc_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  bftc_in_if.sink    in_chan,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam logic [POSX_W-1:0] ROWS_EXT = POSX_W'(GLYPH_ROWS);
  localparam logic [POSX_W-1:0] CELL_EXT = POSX_W'(CELL_W);
  localparam logic [POS_W-1:0]  CELL_POS = POS_W'(CELL_W);

  typedef struct packed {
    cmd_op_t           op;
    logic              clear;
    logic              blank;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] grow;
    logic [MASK_W-1:0] bits;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } s1_t;

  typedef struct packed {
    cmd_op_t           op;
    logic              clear;
    logic              blank;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] grow;
    logic [MASK_W-1:0] bits;
    logic [PIX_W-1:0]  pix;
  } s2_t;

  logic [POS_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [POS_W-1:0]  upd_x, upd_y;
  logic              s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  s1_t               s1_r, s1_nxt, ent;
  s2_t               s2_r, s2_nxt;
  logic              in_ready, accept, want;
  logic              s1_en, s2_en;
  logic              wrap_y, x_fold, back_narrow, load_ok;
  logic [POS_W-1:0]  y_char, x_back, y_back, x_left;
  logic [POSX_W-1:0] x_step;
  logic [PIX_W-1:0]  y_ext, stride_ext, x_ext;

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] y);
    logic [POSX_W-1:0] s;
    s = {1'b0, y} + ROWS_EXT;
    return (s > {1'b0, POS_MAX}) ? POS_MAX : s[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] line_up(input logic [POS_W-1:0] y);
    return ({1'b0, y} >= ROWS_EXT) ? (y - ROWS_EXT[POS_W-1:0]) : '0;
  endfunction

  // Classify the item and work out the cursor it leaves behind.
  always_comb begin
    ent       = '0;
    ent.op    = CMD_DRAW;
    ent.code  = in_chan.char_code;
    ent.grow  = in_chan.glyph_row;
    ent.bits  = in_chan.row_bits;
    ent.blank = 32'(in_chan.char_code) >= GLYPH_COUNT;
    want      = 1'b0;
    upd_x     = cx_r;
    upd_y     = cy_r;

    wrap_y      = ({1'b0, cy_r} + ROWS_EXT) > {1'b0, cfg.screen_height};
    y_char      = wrap_y ? '0 : cy_r;
    x_step      = {1'b0, cx_r} + CELL_EXT;
    x_fold      = (x_step + CELL_EXT) > {1'b0, cfg.screen_width};
    x_back      = (cx_r == '0) ? cfg.screen_width : cx_r;
    y_back      = (cx_r == '0) ? line_up(cy_r) : cy_r;
    back_narrow = x_back < CELL_POS;
    x_left      = back_narrow ? '0 : (x_back - CELL_POS);
    load_ok     = (32'(in_chan.glyph_row) < GLYPH_ROWS) &&
                  (32'(in_chan.char_code) < GLYPH_COUNT);

    case (kind_t'(in_chan.kind))
      KIND_CHAR: begin
        want      = 1'b1;
        ent.op    = CMD_DRAW;
        ent.clear = wrap_y;
        ent.x     = cx_r;
        ent.y     = y_char;
        if (x_fold) begin
          upd_x = '0;
          upd_y = sat_add(y_char);
        end else begin
          upd_x = x_step[POS_W-1:0];
          upd_y = y_char;
        end
      end
      KIND_NEWLINE: begin
        upd_x = '0;
        upd_y = sat_add(cy_r);
      end
      KIND_BACKSPACE: begin
        want   = 1'b1;
        ent.op = CMD_ERASE;
        ent.x  = x_left;
        ent.y  = y_back;
        if (back_narrow) begin
          upd_x = cfg.screen_width;
          upd_y = line_up(y_back);
        end else begin
          upd_x = x_back - CELL_POS;
          upd_y = y_back;
        end
      end
      KIND_LOAD: begin
        want   = load_ok;
        ent.op = CMD_LOAD;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  // Two stages: cursor/classify, then the row offset multiply-accumulate.
  always_comb begin
    s2_en    = !s2_v_r || !q_full;
    s1_en    = !s1_v_r || s2_en;
    in_ready = s1_en;
    accept   = in_chan.valid && in_ready;

    cx_nxt   = accept ? upd_x : cx_r;
    cy_nxt   = accept ? upd_y : cy_r;

    s1_v_nxt = s1_en ? (accept && want) : s1_v_r;
    s1_nxt   = s1_en ? ent : s1_r;

    y_ext      = PIX_W'(s1_r.y);
    stride_ext = PIX_W'(cfg.line_stride);
    x_ext      = PIX_W'(s1_r.x);

    s2_v_nxt = s2_en ? s1_v_r : s2_v_r;
    s2_nxt   = s2_r;
    if (s2_en) begin
      s2_nxt.op    = s1_r.op;
      s2_nxt.clear = s1_r.clear;
      s2_nxt.blank = s1_r.blank;
      s2_nxt.code  = s1_r.code;
      s2_nxt.grow  = s1_r.grow;
      s2_nxt.bits  = s1_r.bits;
      s2_nxt.pix   = y_ext * stride_ext + x_ext;
    end

    q_push       = s2_v_r && !q_full;
    q_cmd.op     = s2_r.op;
    q_cmd.clear  = s2_r.clear;
    q_cmd.blank  = s2_r.blank;
    q_cmd.code   = s2_r.code;
    q_cmd.grow   = s2_r.grow;
    q_cmd.bits   = s2_r.bits;
    q_cmd.addr   = cfg.frame_base + ADDR_W'({s2_r.pix, 2'b00});
  end

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

  a_newline_home: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_chan.kind == KIND_NEWLINE) |=> (cx_r == '0))
    else $error("newline did not return the column to zero");

  a_newline_down: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_chan.kind == KIND_NEWLINE) |=> (cy_r >= $past(cy_r)))
    else $error("newline moved the cursor up");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_en |=> s1_v_r)
    else $error("stalled front stage dropped its command");

endmodule

`default_nettype wire

[design/bftc_queue.sv]
`default_nettype none

module bftc_queue
  import bftc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == CNT_FULL);
    empty   = (cnt_r == '0);
    head    = slots_r[rp_r];
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : (wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : (rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CNT_FULL) || pop)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("command queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("command queue count out of range");

endmodule

`default_nettype wire

[design/bftc_back.sv]
`default_nettype none

module bftc_back
  import bftc_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  bftc_out_if.source out_chan
);

  localparam int FONT_DEPTH = GLYPH_ROWS * GLYPH_COUNT;
  localparam int FIDX_W     = $clog2(FONT_DEPTH);
  localparam int ROW_W      = $clog2(GLYPH_ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

  logic [MASK_W-1:0]  font_mem [FONT_DEPTH];
  logic [MASK_W-1:0]  font_q_r;

  logic               busy_r, busy_nxt;
  logic               clear_pend_r, clear_pend_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  cmd_t               cur_r, cur_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_op_t            out_op_r, out_op_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [MASK_W-1:0]  out_mask_r, out_mask_nxt;
  logic               out_font_r, out_font_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic               out_last_r, out_last_nxt;

  logic               emit_en, row_done, take, wr_en;
  logic [FIDX_W-1:0]  rd_idx, wr_idx;
  logic [ADDR_W-1:0]  stride_bytes;

  always_comb begin
    emit_en      = !out_valid_r || out_chan.ready;
    row_done     = busy_r && emit_en && !clear_pend_r && (row_r == ROW_LAST);
    take         = !q_empty && (!busy_r || row_done);
    q_pop        = take;
    wr_en        = take && (q_head.op == CMD_LOAD);
    wr_idx       = FIDX_W'(32'(q_head.code) * GLYPH_ROWS) + FIDX_W'(q_head.grow);
    rd_idx       = FIDX_W'(32'(cur_r.code) * GLYPH_ROWS) + FIDX_W'(row_r);
    stride_bytes = ADDR_W'({cfg.line_stride, 2'b00});

    busy_nxt       = busy_r;
    clear_pend_nxt = clear_pend_r;
    row_nxt        = row_r;
    addr_nxt       = addr_r;
    cur_nxt        = cur_r;

    if (busy_r && emit_en) begin
      if (clear_pend_r) begin
        clear_pend_nxt = 1'b0;
      end else begin
        row_nxt  = row_r + 1'b1;
        addr_nxt = addr_r + stride_bytes;
      end
    end
    if (row_done) begin
      busy_nxt = 1'b0;
    end
    if (take && (q_head.op != CMD_LOAD)) begin
      busy_nxt       = 1'b1;
      cur_nxt        = q_head;
      row_nxt        = '0;
      clear_pend_nxt = q_head.clear;
      addr_nxt       = q_head.addr;
    end
  end

  // Output register; the font byte lands beside it from the registered read.
  always_comb begin
    out_valid_nxt = emit_en ? busy_r : out_valid_r;
    out_op_nxt    = out_op_r;
    out_addr_nxt  = out_addr_r;
    out_mask_nxt  = out_mask_r;
    out_font_nxt  = out_font_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    if (emit_en && busy_r) begin
      if (clear_pend_r) begin
        out_op_nxt    = OP_CLEAR;
        out_addr_nxt  = cfg.frame_base;
        out_mask_nxt  = '0;
        out_font_nxt  = 1'b0;
        out_color_nxt = cfg.erase_color;
        out_last_nxt  = 1'b0;
      end else begin
        out_op_nxt    = OP_ROW_WRITE;
        out_addr_nxt  = addr_r;
        out_mask_nxt  = (cur_r.op == CMD_ERASE) ? '1 : '0;
        out_font_nxt  = (cur_r.op == CMD_DRAW) && !cur_r.blank;
        out_color_nxt = (cur_r.op == CMD_DRAW) ? cfg.ink_color : cfg.erase_color;
        out_last_nxt  = (row_r == ROW_LAST);
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.op            = out_op_r;
  assign out_chan.pixel_address = out_addr_r;
  assign out_chan.pixel_mask    = out_font_r ? font_q_r : out_mask_r;
  assign out_chan.pixel_color   = out_color_r;
  assign out_chan.last          = out_last_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[wr_idx] <= q_head.bits;
    end
    if (emit_en) begin
      font_q_r <= font_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      clear_pend_r <= 1'b0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      clear_pend_r <= clear_pend_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    cur_r       <= cur_nxt;
    out_op_r    <= out_op_nxt;
    out_addr_r  <= out_addr_nxt;
    out_mask_r  <= out_mask_nxt;
    out_font_r  <= out_font_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_clear_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    clear_pend_r |-> busy_r)
    else $error("screen clear pending with no command in progress");

  a_clear_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_op_r == OP_CLEAR) |-> !out_last_r)
    else $error("screen clear marked as the final beat");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    row_done |=> out_valid_r && out_last_r)
    else $error("final glyph row not marked last");

endmodule

`default_nettype wire

[design/bitmap_font_text_console_core.sv]
// Text console engine for an 8-pixel-wide bitmap font.
// in_chan carries console items: draw a character, newline, backspace, or load
// one glyph row into the font memory. out_chan carries framebuffer beats: a
// masked 8-pixel row write (byte address, mask with the leftmost pixel in the
// MSB, colour) or a whole-screen clear request; last marks the final beat of
// an item. cfg_chan writes the six geometry and colour registers and is
// always ready; write it only while the engine is idle.
// A character gives 16 row-write beats (GLYPH_ROWS in general), plus a
// leading clear beat when the cursor wraps past the bottom edge. The back end
// emits one beat per cycle while out_chan.ready allows, so characters and
// backspaces stream with no gap between items; newlines and font loads take no
// output time, though a font load holds up the back end. An accepted item's
// first beat passes the two front stages, queue, sequencer and output register.
// Reset puts the cursor at the top-left corner and restores the register
// defaults; the font memory is not cleared. When the receiver holds
// out_chan.ready low, the output register holds its beat, the four-entry
// command queue fills, and only then does in_chan.ready drop.
`default_nettype none

module bitmap_font_text_console_core
  import bftc_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  bftc_in_if.sink    in_chan,
  bftc_out_if.source out_chan,
  bftc_cfg_if.sink   cfg_chan
);

  // Configuration registers. The user must change them only between items; the
  // block does not enforce it. Both the front and the back end read them directly.
  cfg_t cfg_r, cfg_nxt;

  // Front-to-queue and queue-to-back command paths.
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_in_cmd, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (reg_idx_t'(cfg_chan.index))
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_chan.data[POS_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_chan.data[POS_W-1:0];
        REG_LINE_STRIDE:   cfg_nxt.line_stride   = cfg_chan.data[POS_W-1:0];
        REG_FRAME_BASE:    cfg_nxt.frame_base    = cfg_chan.data[ADDR_W-1:0];
        REG_INK_COLOR:     cfg_nxt.ink_color     = cfg_chan.data[COLOR_W-1:0];
        REG_ERASE_COLOR:   cfg_nxt.erase_color   = cfg_chan.data[COLOR_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // The register port never stalls.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end owns the cursor: it classifies each item, updates the
  // cursor at once and turns drawing items into commands that carry the
  // address of their top row.
  bftc_front #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_in_cmd)
  );

  // A short queue lets the front keep taking items while the back end works
  // through the rows of an earlier character.
  bftc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // The back end holds the font memory, performs glyph loads in order with
  // the draws around them and sequences the row beats into the output register.
  bftc_back #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[dv/tb_bitmap_font_text_console_core.sv]
`timescale 1ns / 1ps

import bftc_pkg::*;

localparam int          GLYPH_H  = 16;
localparam int unsigned POS_ONES = (1 << POS_W) - 1;

typedef struct packed {
  logic        op;
  logic [47:0] addr;
  logic [7:0]  mask;
  logic [31:0] color;
  logic        last;
} fb_beat_t;

// Tracks cursor, font and registers, and holds the framebuffer beats still owed.
class text_raster_checker;
  bit [12:0]   scr_w, scr_h, stride;
  bit [47:0]   base;
  bit [31:0]   ink, erase;
  int unsigned cur_x, cur_y;
  bit [7:0]    glyph_rows [4096];
  fb_beat_t    due_beats[$];

  function new();
    scr_w  = CFG_RESET.screen_width;
    scr_h  = CFG_RESET.screen_height;
    stride = CFG_RESET.line_stride;
    base   = CFG_RESET.frame_base;
    ink    = CFG_RESET.ink_color;
    erase  = CFG_RESET.erase_color;
    cur_x  = 0;
    cur_y  = 0;
  endfunction

  function void set_reg(reg_idx_t idx, bit [47:0] data);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w  = data[12:0];
      REG_SCREEN_HEIGHT: scr_h  = data[12:0];
      REG_LINE_STRIDE:   stride = data[12:0];
      REG_FRAME_BASE:    base   = data;
      REG_INK_COLOR:     ink    = data[31:0];
      REG_ERASE_COLOR:   erase  = data[31:0];
      default: ;
    endcase
  endfunction

  function int unsigned next_line(int unsigned y);
    return (y + GLYPH_H > POS_ONES) ? POS_ONES : y + GLYPH_H;
  endfunction

  function int unsigned prev_line(int unsigned y);
    return (y >= GLYPH_H) ? y - GLYPH_H : 0;
  endfunction

  // Pixels are four bytes; the address wraps at 48 bits.
  function bit [47:0] row_addr(int unsigned x, int unsigned y);
    longint unsigned xl, yl, pix;
    xl  = x;
    yl  = y;
    pix = xl + yl * stride;
    return base + pix * 4;
  endfunction

  function void note_item(kind_t kind, bit [7:0] code, bit [3:0] grow, bit [7:0] bits);
    fb_beat_t    fresh[$];
    int unsigned left;
    int          r;
    case (kind)
      KIND_CHAR: begin
        if (cur_y + GLYPH_H > scr_h) begin
          cur_y = 0;
          fresh.push_back('{OP_CLEAR, base, 8'h00, erase, 1'b0});
        end
        for (r = 0; r < GLYPH_H; r++)
          fresh.push_back('{OP_ROW_WRITE, row_addr(cur_x, cur_y + r),
                            glyph_rows[{code, 4'(r)}], ink, 1'b0});
        cur_x += CELL_W;
        if (cur_x + CELL_W > scr_w) begin
          cur_x = 0;
          cur_y = next_line(cur_y);
        end
        cur_x &= POS_ONES;
      end
      KIND_NEWLINE: begin
        cur_x = 0;
        cur_y = next_line(cur_y);
      end
      KIND_BACKSPACE: begin
        if (cur_x == 0) begin
          cur_x = scr_w;
          cur_y = prev_line(cur_y);
        end
        left = (cur_x >= CELL_W) ? cur_x - CELL_W : 0;
        for (r = 0; r < GLYPH_H; r++)
          fresh.push_back('{OP_ROW_WRITE, row_addr(left, cur_y + r), 8'hff, erase, 1'b0});
        if (cur_x < CELL_W) begin
          cur_x = scr_w;
          cur_y = prev_line(cur_y);
        end else begin
          cur_x -= CELL_W;
        end
      end
      default: glyph_rows[{code, grow}] = bits;
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) due_beats.push_back(fresh[i]);
  endfunction

  // Returns an empty string when the beat matches the oldest one owed.
  function string check_beat(fb_beat_t got);
    fb_beat_t want;
    string    why;
    if (due_beats.size() == 0)
      return $sformatf("beat with nothing owed: op %0d addr %h", got.op, got.addr);
    want = due_beats.pop_front();
    why  = "";
    if (got.op !== want.op) why = {why, $sformatf(" op %0d/%0d", got.op, want.op)};
    if (got.addr !== want.addr)
      why = {why, $sformatf(" addr %h/%h", got.addr, want.addr)};
    if (got.mask !== want.mask)
      why = {why, $sformatf(" mask %h/%h", got.mask, want.mask)};
    if (got.color !== want.color)
      why = {why, $sformatf(" color %h/%h", got.color, want.color)};
    if (got.last !== want.last)
      why = {why, $sformatf(" last %0d/%0d", got.last, want.last)};
    if (why != "") why = {"beat differs (got/want):", why};
    return why;
  endfunction

  function int pending();
    return due_beats.size();
  endfunction
endclass

module tb_bitmap_font_text_console_core;

  // The receiver holds off this long once, so that the output register and the
  // four-entry command queue fill up and the input side has to stall.
  localparam int HOLD_OFF_CYCLES = 600;
  // Cycles without any handshake on any channel before the run is declared hung.
  localparam int STALL_LIMIT     = 5000;
  // A beat passes the front stages, queue, sequencer and output register, and a
  // font load holds up the back end. This margin covers items that emit nothing.
  localparam int DRAIN_CYCLES    = 16;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  bftc_in_if  in_chan ();
  bftc_out_if out_chan ();
  bftc_cfg_if cfg_chan ();

  bitmap_font_text_console_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  text_raster_checker raster = new();

  int        mismatches   = 0;
  int        idle_cycles  = 0;
  int        items_sent   = 0;
  int        burst_left   = 0;
  bit        hold_off_req = 1'b0;
  fb_beat_t  got_beat;
  string     beat_why;

  // The stimulus only draws codes whose sixteen rows have all been loaded,
  // since an unloaded glyph row has no defined content.
  bit [15:0] rows_loaded [256];
  bit        drawable_flag [256];
  bit [7:0]  drawable[$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Every accepted result beat is compared with the oldest beat still owed.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_beat = '{out_chan.op, out_chan.pixel_address, out_chan.pixel_mask,
                   out_chan.pixel_color, out_chan.last};
      beat_why = raster.check_beat(got_beat);
      if (beat_why != "") report_mismatch(beat_why);
    end
  end

  // The watchdog restarts its count on any handshake on any of the three channels.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: it switches between stall patterns of random length, and it
  // takes the one long hold-off when the stimulus asks for it.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       period;
    out_chan.ready = 1'b0;
    mode           = RX_ALWAYS;
    mode_left      = 0;
    period         = 2;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(3));
        mode_left = $urandom_range(40, 300);
        period    = $urandom_range(2, 9);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS:   out_chan.ready = 1'b1;
        RX_MOSTLY:   out_chan.ready = ($urandom_range(9) < 7);
        RX_PERIODIC: out_chan.ready = (mode_left % period) != 0;
        default:     out_chan.ready = ($urandom_range(9) < 3);
      endcase
    end
  end

  // Offers one item and returns at the falling edge after its beat is taken.
  // The sender works in bursts; between bursts valid drops for a random gap,
  // and some bursts follow each other with no gap at all.
  task automatic send_item(kind_t kind, bit [7:0] code, bit [3:0] grow, bit [7:0] bits);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid     = 1'b1;
    in_chan.kind      = kind;
    in_chan.char_code = code;
    in_chan.glyph_row = grow;
    in_chan.row_bits  = bits;
    do @(posedge clk); while (!in_chan.ready);
    raster.note_item(kind, code, grow, bits);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(bit [7:0] code, bit [3:0] grow, bit [7:0] bits);
    send_item(KIND_LOAD, code, grow, bits);
    rows_loaded[code][grow] = 1'b1;
    if (rows_loaded[code] == 16'hffff && !drawable_flag[code]) begin
      drawable_flag[code] = 1'b1;
      drawable.push_back(code);
    end
  endtask

  // Font rows lean toward the all-clear and all-set extremes.
  function automatic bit [7:0] pick_bits();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // A whole glyph, with its rows loaded in shuffled order.
  task automatic load_glyph(bit [7:0] code);
    int order[$];
    for (int i = 0; i < GLYPH_H; i++) order.push_back(i);
    order.shuffle();
    foreach (order[i]) send_load(code, 4'(order[i]), pick_bits());
  endtask

  // Mostly characters from loaded glyphs, with newlines, backspaces, whole
  // glyph loads, and stray single-row loads mixed in. Unused fields are random.
  task automatic random_item();
    int roll;
    roll = $urandom_range(99);
    if (drawable.size() < 3 || roll < 6)
      load_glyph(drawable_flag[0] ? 8'($urandom) : 8'h00);
    else if (roll < 12)
      send_load(8'($urandom), 4'($urandom), pick_bits());
    else if (roll < 68)
      send_item(KIND_CHAR, drawable[$urandom_range(drawable.size() - 1)],
                4'($urandom), 8'($urandom));
    else if (roll < 82)
      send_item(KIND_NEWLINE, 8'($urandom), 4'($urandom), 8'($urandom));
    else
      send_item(KIND_BACKSPACE, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_item();
  endtask

  // Waits until every owed beat has come out, then lets the pipeline empty.
  task automatic settle();
    in_chan.valid = 1'b0;
    while (raster.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [47:0] data);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = data;
    do @(posedge clk); while (!cfg_chan.ready);
    raster.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(bit [12:0] w, bit [12:0] h, bit [12:0] s,
                                bit [47:0] fb, bit [31:0] fg, bit [31:0] bg);
    write_reg(REG_SCREEN_WIDTH, 48'(w));
    write_reg(REG_SCREEN_HEIGHT, 48'(h));
    write_reg(REG_LINE_STRIDE, 48'(s));
    write_reg(REG_FRAME_BASE, fb);
    write_reg(REG_INK_COLOR, 48'(fg));
    write_reg(REG_ERASE_COLOR, 48'(bg));
    cfg_chan.valid = 1'b0;
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.kind      = KIND_CHAR;
    in_chan.char_code = 8'h00;
    in_chan.glyph_row = 4'h0;
    in_chan.row_bits  = 8'h00;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = REG_SCREEN_WIDTH;
    cfg_chan.data     = 48'h0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset settings. A backspace at the origin clamps
    // the row at the top and wraps to the right edge. Glyph 0xff gets the
    // extreme row patterns, is drawn twice, and a backspace at column zero
    // then steps back up to the end of the previous line.
    send_item(KIND_BACKSPACE, 8'h00, 4'h0, 8'h00);
    send_item(KIND_NEWLINE, 8'hff, 4'hf, 8'hff);
    for (int r = 0; r < GLYPH_H; r++) begin
      case (r)
        0:       send_load(8'hff, 4'(r), 8'h00);
        1:       send_load(8'hff, 4'(r), 8'hff);
        2:       send_load(8'hff, 4'(r), 8'h80);
        3:       send_load(8'hff, 4'(r), 8'h01);
        default: send_load(8'hff, 4'(r), pick_bits());
      endcase
    end
    send_item(KIND_CHAR, 8'hff, 4'h0, 8'h00);
    send_item(KIND_CHAR, 8'hff, 4'hf, 8'hff);
    send_item(KIND_NEWLINE, 8'h00, 4'h0, 8'h00);
    send_item(KIND_BACKSPACE, 8'hff, 4'hf, 8'hff);
    send_item(KIND_BACKSPACE, 8'h00, 4'h0, 8'h00);
    run_random(90);

    // Smallest screen: every character wraps at the right and bottom edges,
    // and the frame base sits just below the top of the address space.
    settle();
    apply_settings(13'd8, 13'd16, 13'd8, 48'hffff_ffff_fffc, 32'h0, 32'hffff_ffff);
    run_random(80);

    // A width that is no multiple of the cell makes backspace meet a narrow
    // cell at the left edge. The long receiver hold-off happens here.
    settle();
    apply_settings(13'd13, 13'd40, 13'd4096, {16'($urandom), 32'($urandom)},
                   32'($urandom), 32'($urandom));
    hold_off_req = 1'b1;
    run_random(90);

    // Largest screen with the frame base near the top of the address space.
    // A run of newlines moves the cursor far enough down that the row
    // addresses wrap past the end of the space; a character and two
    // backspaces then work from there.
    settle();
    apply_settings(13'd4096, 13'd4096, 13'd4096, 48'hffff_fff0_0000, 32'hffff_ffff, 32'h0);
    repeat (20) send_item(KIND_NEWLINE, 8'($urandom), 4'($urandom), 8'($urandom));
    send_item(KIND_CHAR, drawable[0], 4'h0, 8'h00);
    send_item(KIND_BACKSPACE, 8'h00, 4'h0, 8'h00);
    send_item(KIND_BACKSPACE, 8'hff, 4'hf, 8'hff);
    run_random(60);

    // Random geometry and colors within the legal ranges.
    settle();
    apply_settings(13'($urandom_range(8, 4096)), 13'($urandom_range(16, 4096)),
                   13'($urandom_range(8, 4096)), {16'($urandom), 32'($urandom)},
                   32'($urandom), 32'($urandom));
    run_random(90);

    settle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
